// ===== design/bsa_pkg.sv =====
package bsa_pkg;

	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = 32;
	localparam int MAX_SLOTS = 1024;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = $clog2(NUM_WORDS);
	localparam int IDX_W     = WADDR_W + BIT_W;
	localparam int CAP_W     = IDX_W + 1;
	localparam int HINT_W    = WADDR_W + 1;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [OP_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [OP_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_DOUBLE = 2'd3;

	function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== design/bsa_ram.sv =====
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/bitmap_slot_allocator.sv =====
// Fixed-slot allocator over a used bitmap of 1024 slots kept as 32 words of 32 bits in one
// synchronous RAM. Each request carries its operation in s_tuser (0 allocate, 1 free,
// 2 clear all) and the slot to release in s_tdata; each request yields exactly one result
// with the status in m_tuser and the granted slot, the used count and the full and empty
// flags in m_tdata. Requests are handled one at a time, and the cost is set by the RAM
// reads: clear, mode three, an out-of-range free and an allocate refused on the count read
// no word; a free reads the word of its index; an allocate reads the hinted word, and also
// the next word when it grants the last bit of that word and the next slot is within
// capacity; an allocate that falls back to the scan reads one word per cycle from word 0,
// after the hinted word if that was read first. A finished result sits in an output
// register, so the next request is taken while it waits. A clear empties the store through
// per-word valid flags; no clearing pass is needed after reset. Capacity is to be written
// through cfg_we and cfg_wdata while no request is in flight; the block does not enforce it.
module bitmap_slot_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsa_pkg::CAP_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// free_index [9:0], zero [15:10]
	input  logic [bsa_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode [1:0]
	input  logic [bsa_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// slot_index [9:0], used_count [20:10], is_full [21], is_empty [22], zero [23]
	output logic [bsa_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status [1:0]
	output logic [bsa_pkg::STAT_W-1:0]      m_tuser
);

	import bsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HRD,
		S_HCHK,
		S_NRD,
		S_NCHK,
		S_SCAN,
		S_FRD,
		S_FCHK,
		S_PUSH
	} state_t;

	state_t                 state_q;
	logic [CAP_W-1:0]       cap_q;
	logic [NUM_WORDS-1:0]   valid_q;
	logic [IDX_W-1:0]       fidx_q;
	logic [HINT_W-1:0]      hint_q;
	logic [CAP_W-1:0]       count_q;
	logic [STAT_W-1:0]      status_q;
	logic [IDX_W-1:0]       slot_q;
	logic [WADDR_W-1:0]     addr_q;
	logic [WADDR_W-1:0]     iss_q;
	logic                   rd_vld_s1;
	logic [WADDR_W-1:0]     rd_w_s1;
	logic                   val_s1;

	logic                   m_tvalid_q;
	logic [STAT_W-1:0]      m_status_q;
	logic [IDX_W-1:0]       m_slot_q;
	logic [CAP_W-1:0]       m_count_q;
	logic                   m_full_q;
	logic                   m_empty_q;

	logic                   ram_we;
	logic [WADDR_W-1:0]     ram_waddr;
	logic [WORD_BITS-1:0]   ram_wdata;
	logic [WADDR_W-1:0]     ram_raddr;
	logic [WORD_BITS-1:0]   ram_rdata;

	logic [CAP_W-1:0]       eff_cap;
	logic [CAP_W-1:0]       cap_round;
	logic [HINT_W-1:0]      words;
	logic [IDX_W-1:0]       in_fidx;
	logic [HINT_W-1:0]      hint_w;
	logic                   hint_drop;
	logic [WORD_BITS-1:0]   rword;
	logic                   wfull;
	logic [BIT_W-1:0]       lz;
	logic [WORD_BITS-1:0]   setw;
	logic                   new_full;
	logic [IDX_W-1:0]       hidx;
	logic [IDX_W-1:0]       sidx;
	logic                   hidx_ge;
	logic                   sidx_ge;
	logic                   hnext_lt;
	logic                   scan_last;
	logic                   free_hit;

	assign eff_cap   = (cap_q > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : cap_q;
	assign cap_round = eff_cap + CAP_W'(WORD_BITS - 1);
	assign words     = cap_round[CAP_W-1:BIT_W];
	assign in_fidx   = s_tdata[IDX_W-1:0];
	assign hint_w    = hint_q - HINT_W'(1);
	assign hint_drop = {hint_w, {BIT_W{1'b0}}} >= eff_cap;

	assign rword     = val_s1 ? ram_rdata : '0;
	assign wfull     = &rword;
	assign lz        = lowest_zero(rword);
	assign setw      = rword | (WORD_BITS'(1) << lz);
	assign new_full  = &setw;
	assign hidx      = {addr_q, lz};
	assign sidx      = {rd_w_s1, lz};
	assign hidx_ge   = {1'b0, hidx} >= eff_cap;
	assign sidx_ge   = {1'b0, sidx} >= eff_cap;
	assign hnext_lt  = ({1'b0, hidx} + CAP_W'(1)) < eff_cap;
	assign scan_last = ({1'b0, rd_w_s1} + HINT_W'(1)) >= words;
	assign free_hit  = rword[fidx_q[BIT_W-1:0]];

	assign ram_raddr = (state_q == S_SCAN) ? iss_q : addr_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = setw;
		case (state_q)
			S_HCHK: begin
				ram_we = !wfull && !hidx_ge;
			end
			S_SCAN: begin
				ram_we    = rd_vld_s1 && !wfull && !sidx_ge;
				ram_waddr = rd_w_s1;
			end
			S_FCHK: begin
				ram_we    = free_hit;
				ram_wdata = rword & ~(WORD_BITS'(1) << fidx_q[BIT_W-1:0]);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bsa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cap_q      <= CAP_W'(MAX_SLOTS);
			valid_q    <= '0;
			fidx_q     <= '0;
			hint_q     <= HINT_W'(1);
			count_q    <= '0;
			status_q   <= STAT_OK;
			slot_q     <= '0;
			addr_q     <= '0;
			iss_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_w_s1    <= '0;
			val_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_status_q <= STAT_OK;
			m_slot_q   <= '0;
			m_count_q  <= '0;
			m_full_q   <= 1'b0;
			m_empty_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			val_s1 <= valid_q[ram_raddr];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			m_tvalid_q <= (state_q == S_PUSH) || (m_tvalid_q && !m_tready);
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						fidx_q   <= in_fidx;
						status_q <= STAT_OK;
						slot_q   <= '0;
						case (s_tuser)
							MODE_ALLOC: begin
								if (count_q >= eff_cap) begin
									status_q <= STAT_FULL;
									state_q  <= S_PUSH;
								end else if (hint_q == '0 || hint_drop) begin
									hint_q    <= '0;
									iss_q     <= '0;
									rd_vld_s1 <= 1'b0;
									state_q   <= S_SCAN;
								end else begin
									addr_q  <= hint_w[WADDR_W-1:0];
									state_q <= S_HRD;
								end
							end
							MODE_FREE: begin
								if ({1'b0, in_fidx} >= eff_cap) begin
									status_q <= STAT_RANGE;
									state_q  <= S_PUSH;
								end else begin
									addr_q  <= in_fidx[IDX_W-1:BIT_W];
									state_q <= S_FRD;
								end
							end
							MODE_CLEAR: begin
								valid_q <= '0;
								count_q <= '0;
								hint_q  <= HINT_W'(1);
								state_q <= S_PUSH;
							end
							default: begin
								state_q <= S_PUSH;
							end
						endcase
					end
				end
				S_HRD: begin
					state_q <= S_HCHK;
				end
				S_HCHK: begin
					if (wfull || hidx_ge) begin
						if (!wfull) begin
							hint_q <= '0;
						end
						iss_q     <= '0;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_SCAN;
					end else begin
						slot_q  <= hidx;
						count_q <= count_q + CAP_W'(1);
						state_q <= S_PUSH;
						if (new_full) begin
							hint_q <= '0;
							if (lz == '1 && hnext_lt) begin
								addr_q  <= addr_q + WADDR_W'(1);
								state_q <= S_NRD;
							end
						end
					end
				end
				S_NRD: begin
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					if (!rword[0]) begin
						hint_q <= {1'b0, addr_q} + HINT_W'(1);
					end
					state_q <= S_PUSH;
				end
				S_SCAN: begin
					iss_q     <= iss_q + WADDR_W'(1);
					rd_vld_s1 <= 1'b1;
					rd_w_s1   <= iss_q;
					if (rd_vld_s1) begin
						if (wfull) begin
							if (scan_last) begin
								status_q <= STAT_FULL;
								state_q  <= S_PUSH;
							end
						end else if (sidx_ge) begin
							status_q <= STAT_FULL;
							state_q  <= S_PUSH;
						end else begin
							slot_q  <= sidx;
							count_q <= count_q + CAP_W'(1);
							if (!new_full) begin
								hint_q <= {1'b0, rd_w_s1} + HINT_W'(1);
							end
							state_q <= S_PUSH;
						end
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (!free_hit) begin
						status_q <= STAT_DOUBLE;
					end else begin
						if (count_q != '0) begin
							count_q <= count_q - CAP_W'(1);
						end
						if (hint_q == '0) begin
							hint_q <= {1'b0, fidx_q[IDX_W-1:BIT_W]} + HINT_W'(1);
						end
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!m_tvalid_q || m_tready) begin
						m_status_q <= status_q;
						m_slot_q   <= slot_q;
						m_count_q  <= count_q;
						m_full_q   <= (count_q == eff_cap);
						m_empty_q  <= (count_q == '0);
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {1'b0, m_empty_q, m_full_q, m_count_q, m_slot_q};

endmodule

// ===== tb/sv/tb_bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_slot_allocator;
	import bsa_pkg::*;

	localparam logic [OP_W-1:0] MODE_NONE = 2'd3;
	localparam int PHASES = 14;
	localparam int PHASE_CAP [PHASES] = '{32, 33, 40, 20, 1, 2, 64, 31, 1024, 7, 0, 2047, 100, 0};
	localparam int PHASE_LEN [PHASES] = '{65, 65, 65, 65, 65, 65, 65, 65, 180, 65, 15, 40, 65, 65};
	localparam int PHASE_ALLOC [PHASES] = '{70, 50, 75, 50, 60, 60, 75, 50, 85, 60, 50, 60, 70, 65};

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  slot;
		logic [CAP_W-1:0]  count;
		logic              full;
		logic              empty;
	} alloc_result_t;

	class slot_scoreboard;
		logic [WORD_BITS-1:0] used_words [NUM_WORDS];
		int unsigned hint;
		int unsigned count;
		int unsigned capacity;
		int unsigned errors;
		alloc_result_t pending_results [$];

		function new();
			foreach (used_words[w]) used_words[w] = '0;
			hint = 1;
			count = 0;
			capacity = MAX_SLOTS;
			errors = 0;
		endfunction

		function void report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endfunction

		function int unsigned eff_cap();
			return (capacity > MAX_SLOTS) ? MAX_SLOTS : capacity;
		endfunction

		function int unsigned first_clear_bit(logic [WORD_BITS-1:0] w);
			for (int b = 0; b < WORD_BITS; b++) begin
				if (!w[b]) return b;
			end
			return WORD_BITS;
		endfunction

		function bit slot_used(int unsigned idx);
			if (idx / WORD_BITS >= NUM_WORDS) return 1'b0;
			return used_words[idx / WORD_BITS][idx % WORD_BITS];
		endfunction

		function void point_hint(int unsigned idx);
			hint = idx / WORD_BITS + 1;
		endfunction

		function bit alloc_from_hint(int unsigned cap, output int unsigned slot);
			int unsigned w;
			int unsigned idx;
			slot = 0;
			if (hint == 0) return 1'b0;
			w = hint - 1;
			if (w >= NUM_WORDS || w * WORD_BITS >= cap) begin
				hint = 0;
				return 1'b0;
			end
			if (&used_words[w]) return 1'b0;
			idx = w * WORD_BITS + first_clear_bit(used_words[w]);
			if (idx >= cap) begin
				hint = 0;
				return 1'b0;
			end
			used_words[w][idx % WORD_BITS] = 1'b1;
			if (&used_words[w]) begin
				hint = 0;
				if (idx + 1 < cap && !slot_used(idx + 1)) point_hint(idx + 1);
			end
			slot = idx;
			return 1'b1;
		endfunction

		function bit alloc_from_scan(int unsigned cap, output int unsigned slot);
			int unsigned words;
			int unsigned w;
			int unsigned idx;
			slot = 0;
			words = (cap + WORD_BITS - 1) / WORD_BITS;
			if (words > NUM_WORDS) words = NUM_WORDS;
			w = 0;
			while (w < words && &used_words[w]) w++;
			if (w >= words) return 1'b0;
			idx = w * WORD_BITS + first_clear_bit(used_words[w]);
			if (idx >= cap) return 1'b0;
			used_words[w][idx % WORD_BITS] = 1'b1;
			if (!(&used_words[w])) point_hint(idx);
			slot = idx;
			return 1'b1;
		endfunction

		function void note_request(logic [OP_W-1:0] mode, logic [IDX_W-1:0] idx);
			int unsigned cap;
			int unsigned got;
			bit granted;
			alloc_result_t res;
			cap = eff_cap();
			res = '0;
			res.status = STAT_OK;
			case (mode)
				MODE_ALLOC: begin
					if (count >= cap) begin
						res.status = STAT_FULL;
					end else begin
						granted = alloc_from_hint(cap, got);
						if (!granted) granted = alloc_from_scan(cap, got);
						if (granted) begin
							res.slot = got[IDX_W-1:0];
							count++;
						end else begin
							res.status = STAT_FULL;
						end
					end
				end
				MODE_FREE: begin
					if (idx >= cap) begin
						res.status = STAT_RANGE;
					end else if (!slot_used(idx)) begin
						res.status = STAT_DOUBLE;
					end else begin
						used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
						if (count > 0) count--;
						if (hint == 0) point_hint(idx);
					end
				end
				MODE_CLEAR: begin
					foreach (used_words[w]) used_words[w] = '0;
					count = 0;
					hint = 1;
				end
				default: begin
				end
			endcase
			res.count = count[CAP_W-1:0];
			res.full = (count == cap);
			res.empty = (count == 0);
			pending_results.push_back(res);
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.slot !== want.slot)
				report($sformatf("slot_index %0d, expected %0d", got.slot, want.slot));
			if (got.count !== want.count)
				report($sformatf("used_count %0d, expected %0d", got.count, want.count));
			if (got.full !== want.full)
				report($sformatf("is_full %0b, expected %0b", got.full, want.full));
			if (got.empty !== want.empty)
				report($sformatf("is_empty %0b, expected %0b", got.empty, want.empty));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CAP_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [OP_W-1:0]        s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [STAT_W-1:0]      m_tuser;

	slot_scoreboard sb;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold_left = 0;

	bitmap_slot_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result({m_tuser, m_tdata[9:0], m_tdata[20:10], m_tdata[21], m_tdata[22]});
		end
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			m_tready <= rx_quiet || ($urandom_range(99) >= 23);
		end
	end

	task automatic send_request(input logic [OP_W-1:0] mode, input logic [IDX_W-1:0] idx);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - IDX_W){1'b0}}, idx};
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		sb.note_request(mode, idx);
		if (!tx_quiet && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 23);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.capacity = value;
	endtask

	task automatic random_request(input int alloc_pct);
		int unsigned r;
		int unsigned cap;
		int unsigned sel;
		int unsigned idx;
		r = $urandom_range(99);
		cap = sb.eff_cap();
		sel = $urandom_range(9);
		if (sel == 0 || cap == 0) begin
			idx = $urandom_range(1023);
		end else if (sel == 1) begin
			idx = (cap + 2 > 1023) ? $urandom_range(1023, cap - 3) : $urandom_range(cap + 2, cap);
		end else begin
			idx = $urandom_range(cap - 1);
		end
		if (r < alloc_pct) begin
			send_request(MODE_ALLOC, IDX_W'($urandom));
		end else if (r < 96) begin
			send_request(MODE_FREE, idx[IDX_W-1:0]);
		end else if (r < 98) begin
			send_request(MODE_CLEAR, IDX_W'($urandom));
		end else begin
			send_request(MODE_NONE, IDX_W'($urandom));
		end
	endtask

	initial begin
		int cap;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '1);
		send_request(MODE_FREE, 10'd0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 10'd5);
		send_request(MODE_FREE, 10'd1023);
		send_request(MODE_NONE, '1);
		send_request(MODE_CLEAR, '1);
		send_request(MODE_ALLOC, '0);
		write_capacity(11'd0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 10'd0);
		write_capacity(11'd2047);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 10'd1023);
		write_capacity(11'd1);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 10'd0);
		send_request(MODE_FREE, 10'd1);
		send_request(MODE_ALLOC, '0);

		for (int p = 0; p < PHASES; p++) begin
			cap = (p == PHASES - 1) ? $urandom_range(128, 3) : PHASE_CAP[p];
			write_capacity(cap[CAP_W-1:0]);
			tx_quiet = (p == 6);
			rx_quiet = (p == 6);
			if (p == 2) rx_hold_left = 300;
			for (int i = 0; i < PHASE_LEN[p]; i++) begin
				if (p == 8 && i == PHASE_LEN[p] / 2) settle();
				random_request(PHASE_ALLOC[p]);
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		settle();
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== bitmap_slot_allocator.f =====
design/bsa_pkg.sv
design/bsa_ram.sv
design/bitmap_slot_allocator.sv
tb/sv/tb_bitmap_slot_allocator.sv
